// ===== design/esc_pkg.sv =====
// shared types, codes and arithmetic helpers for the sensor compensation core
`default_nettype none
package esc_pkg;

  // disabled-channel codes of the raw data words
  localparam logic [23:0] TEMP_OFF_CODE  = 24'h800000;
  localparam logic [23:0] PRESS_OFF_CODE = 24'h800000;
  localparam logic [15:0] HUM_OFF_CODE   = 16'h8000;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_MIXED   = 3'd3;
  localparam logic [2:0] CFG_HUM     = 3'd4;

  // packed calibration registers
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [47:0] mixed;
    logic [31:0] hum;
  } esc_cfg_t;

  // item handed from the temperature front end to the back end
  typedef struct packed {
    logic [31:0] tcent;
    logic [31:0] tfine;
    logic [23:0] rp;
    logic [15:0] rh;
    logic        tv;
  } esc_item_t;

  function automatic logic [31:0] sra32(input logic [31:0] v, input int unsigned n);
    return 32'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sra64(input logic [63:0] v, input int unsigned n);
    return 64'($signed(v) >>> n);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== design/esc_mul.sv =====
// shared 64-bit wrapping multiplier built from one 32x32 multiplier over three partial products
`default_nettype none
module esc_mul (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic             done,
  output logic [63:0]      prod
);

  logic [63:0] x_r, y_r, acc_r;
  logic [1:0]  ph_r;
  logic        run_r, done_r;
  logic [31:0] opa, opb;
  logic [63:0] m;

  // partial product select: lo*lo, hi*lo, lo*hi
  always_comb begin
    opa = x_r[31:0];
    opb = y_r[31:0];
    if (ph_r == 2'd1) begin
      opa = x_r[63:32];
    end else if (ph_r == 2'd2) begin
      opb = y_r[63:32];
    end
    m = 64'(opa) * 64'(opb);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= 2'd0;
      end else if (run_r) begin
        if (ph_r == 2'd2) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x;
      y_r <= y;
    end else if (run_r) begin
      if (ph_r == 2'd0) begin
        acc_r <= m;
      end else begin
        acc_r <= acc_r + {m[31:0], 32'd0};
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ===== design/esc_div.sv =====
// signed 64-bit divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module esc_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [63:0]      quo
);

  logic [63:0] q_r, rem_r, dm_r;
  logic [6:0]  cnt_r;
  logic        run_r, done_r, neg_r;
  logic [64:0] rem_sh;
  logic [65:0] diff;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, q_r[63]};
    diff   = {1'b0, rem_sh} - {2'b00, dm_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= 7'd64;
      end else if (run_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // magnitudes and shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[63] ? (64'd0 - num) : num;
      dm_r  <= den[63] ? (64'd0 - den) : den;
      rem_r <= 64'd0;
      neg_r <= num[63] ^ den[63];
    end else if (run_r) begin
      if (!diff[65]) begin
        rem_r <= diff[63:0];
        q_r   <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh[63:0];
        q_r   <= {q_r[62:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (64'd0 - q_r) : q_r;

endmodule
`default_nettype wire

// ===== design/esc_queue.sv =====
// small item queue between the front end and the back end
`default_nettype none
module esc_queue
  import esc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire esc_item_t                  push_item,
  input  wire logic                       pop,
  output esc_item_t                       head,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  esc_item_t     mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign head  = mem_r[rd_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r != CW'(DEPTH))
    else $error("queue overflow");

endmodule
`default_nettype wire

// ===== design/esc_front.sv =====
// front end: accepts items and computes the fine temperature in a three-stage pipeline
`default_nettype none
module esc_front
  import esc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [23:0]            raw_temperature,
  input  wire logic [23:0]            raw_pressure,
  input  wire logic [15:0]            raw_humidity,
  input  wire logic [47:0]            temp_coeffs,
  input  wire logic [$clog2(DEPTH+1)-1:0] q_count,
  output logic                        push,
  output esc_item_t                   push_item
);

  localparam int CW = $clog2(DEPTH + 1);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] m1_r, dd_r, v1v_r, m2_r, tfine_r;
  logic [23:0] rp1_r, rp2_r, rp3_r;
  logic [15:0] rh1_r, rh2_r, rh3_r;
  logic        tv1_r, tv2_r, tv3_r;
  logic [CW:0] occ;
  logic        accept;
  logic [19:0] adc;
  logic [31:0] t1, t2, t3, x1, d, tc;

  // credit check: queue plus items in flight
  assign occ    = {1'b0, q_count} + (CW+1)'(v1_r) + (CW+1)'(v2_r) + (CW+1)'(v3_r);
  assign busy   = (occ >= (CW+1)'(DEPTH));
  assign accept = start && !busy;

  // stage 1 operands
  always_comb begin
    adc = raw_temperature[23:4];
    t1  = {16'd0, temp_coeffs[15:0]};
    t2  = {{16{temp_coeffs[31]}}, temp_coeffs[31:16]};
    t3  = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
    x1  = 32'(adc[19:3]) - (t1 << 1);
    d   = 32'(adc[19:4]) - t1;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // temperature datapath
  always_ff @(posedge clk) begin
    m1_r    <= x1 * t2;
    dd_r    <= d * d;
    tv1_r   <= (raw_temperature != TEMP_OFF_CODE);
    rp1_r   <= raw_pressure;
    rh1_r   <= raw_humidity;
    v1v_r   <= sra32(m1_r, 11);
    m2_r    <= sra32(dd_r, 12) * t3;
    tv2_r   <= tv1_r;
    rp2_r   <= rp1_r;
    rh2_r   <= rh1_r;
    tfine_r <= v1v_r + sra32(m2_r, 14);
    tv3_r   <= tv2_r;
    rp3_r   <= rp2_r;
    rh3_r   <= rh2_r;
  end

  // hundredths of a degree, zeroed when temperature is off
  assign tc = sra32(tfine_r * 32'd5 + 32'd128, 8);

  always_comb begin
    push            = v3_r;
    push_item.tcent = tv3_r ? tc : 32'd0;
    push_item.tfine = tv3_r ? tfine_r : 32'd0;
    push_item.rp    = rp3_r;
    push_item.rh    = rh3_r;
    push_item.tv    = tv3_r;
  end

endmodule
`default_nettype wire

// ===== design/esc_back.sv =====
// back end: sequencer for pressure and humidity over a shared multiplier and a divider
`default_nettype none
module esc_back
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire esc_item_t   head,
  output logic             pop,
  input  wire esc_cfg_t    cfg,
  output logic             out_valid,
  output logic [31:0]      out_temperature_centi,
  output logic [31:0]      out_fine_temperature,
  output logic [31:0]      out_pressure_pa,
  output logic [16:0]      out_humidity_q10,
  output logic             out_temp_valid,
  output logic             out_press_valid,
  output logic             out_hum_valid
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DIVGO = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // multiply steps
  localparam logic [4:0] SP_AA   = 5'd0;
  localparam logic [4:0] SP_B6   = 5'd1;
  localparam logic [4:0] SP_B5   = 5'd2;
  localparam logic [4:0] SP_A3   = 5'd3;
  localparam logic [4:0] SP_A2   = 5'd4;
  localparam logic [4:0] SP_A1   = 5'd5;
  localparam logic [4:0] SP_NUM  = 5'd6;
  localparam logic [4:0] SP_P9   = 5'd7;
  localparam logic [4:0] SP_P9S  = 5'd8;
  localparam logic [4:0] SP_P8   = 5'd9;
  localparam logic [4:0] SH_H5   = 5'd10;
  localparam logic [4:0] SH_H6   = 5'd11;
  localparam logic [4:0] SH_H3   = 5'd12;
  localparam logic [4:0] SH_B12  = 5'd13;
  localparam logic [4:0] SH_H2   = 5'd14;
  localparam logic [4:0] SH_TATB = 5'd15;
  localparam logic [4:0] SH_VV   = 5'd16;
  localparam logic [4:0] SH_H1   = 5'd17;

  logic [2:0]  state_r;
  logic [4:0]  step_r;
  logic        hum_en_r, pv_r, hv_r, tv_r;
  logic [31:0] tcent_r, tfine_r, press_r, hx_r, ta_r, b1_r, b2_r, c_r, tb_r, v_r, u_r;
  logic [15:0] rh_r;
  logic [16:0] hum_r;
  logic [63:0] a_r, aa_r, b_r, a2_r, aq_r, num_r, p_r, s_r, t_r, a3_r;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mx, my, mprod, quo;
  logic [31:0] m32, vv32;
  logic [63:0] b3, pp, rr;
  logic        press_en, hum_en;

  // coefficient fields
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  always_comb begin
    p1 = {48'd0, cfg.press_a[15:0]};
    p2 = sx16(cfg.press_a[31:16]);
    p3 = sx16(cfg.press_a[47:32]);
    p4 = sx16(cfg.press_a[63:48]);
    p5 = sx16(cfg.press_b[15:0]);
    p6 = sx16(cfg.press_b[31:16]);
    p7 = sx16(cfg.press_b[47:32]);
    p8 = sx16(cfg.press_b[63:48]);
    p9 = sx16(cfg.mixed[15:0]);
    h1 = {24'd0, cfg.mixed[23:16]};
    h2 = {{16{cfg.mixed[39]}}, cfg.mixed[39:24]};
    h3 = {24'd0, cfg.mixed[47:40]};
    h4 = {{20{cfg.hum[11]}}, cfg.hum[11:0]};
    h5 = {{20{cfg.hum[23]}}, cfg.hum[23:12]};
    h6 = {{24{cfg.hum[31]}}, cfg.hum[31:24]};
  end

  // operand select per step
  always_comb begin
    mx = 64'd0;
    my = 64'd0;
    unique case (step_r)
      SP_AA:   begin mx = a_r;                          my = a_r;   end
      SP_B6:   begin mx = aa_r;                         my = p6;    end
      SP_B5:   begin mx = a_r;                          my = p5;    end
      SP_A3:   begin mx = aa_r;                         my = p3;    end
      SP_A2:   begin mx = a_r;                          my = p2;    end
      SP_A1:   begin mx = 64'h0000_8000_0000_0000 + a2_r; my = p1;  end
      SP_NUM:  begin mx = (p_r << 31) - b_r;            my = 64'd3125; end
      SP_P9:   begin mx = p9;                           my = s_r;   end
      SP_P9S:  begin mx = t_r;                          my = s_r;   end
      SP_P8:   begin mx = p8;                           my = p_r;   end
      SH_H5:   begin mx = {32'd0, h5};                  my = {32'd0, hx_r}; end
      SH_H6:   begin mx = {32'd0, hx_r};                my = {32'd0, h6};   end
      SH_H3:   begin mx = {32'd0, hx_r};                my = {32'd0, h3};   end
      SH_B12:  begin mx = {32'd0, b1_r};                my = {32'd0, b2_r}; end
      SH_H2:   begin mx = {32'd0, c_r};                 my = {32'd0, h2};   end
      SH_TATB: begin mx = {32'd0, ta_r};                my = {32'd0, tb_r}; end
      SH_VV:   begin mx = {32'd0, sra32(v_r, 15)};      my = {32'd0, sra32(v_r, 15)}; end
      SH_H1:   begin mx = {32'd0, u_r};                 my = {32'd0, h1};   end
      default: begin mx = 64'd0;                        my = 64'd0; end
    endcase
  end

  assign mul_start = (state_r == ST_ISSUE);
  assign div_start = (state_r == ST_DIVGO);
  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign m32       = mprod[31:0];
  assign press_en  = head.tv && (head.rp != PRESS_OFF_CODE);
  assign hum_en    = head.tv && (head.rh != HUM_OFF_CODE);

  // final pressure and humidity terms
  always_comb begin
    b3   = sra64(mprod, 19);
    pp   = sra64(p_r + a3_r + b3, 8) + (p7 << 4);
    rr   = sra64(pp, 8);
    vv32 = v_r - sra32(m32, 4);
  end

  esc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .prod  (mprod)
  );

  esc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (aq_r),
    .done  (div_done),
    .quo   (quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SP_AA;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (press_en) begin
              step_r  <= SP_AA;
              state_r <= ST_ISSUE;
            end else if (hum_en) begin
              step_r  <= SH_H5;
              state_r <= ST_ISSUE;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_ISSUE: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done) begin
            state_r <= ST_ISSUE;
            step_r  <= step_r + 5'd1;
            if (step_r == SP_A1 && sra64(mprod, 33) == 64'd0) begin
              state_r <= hum_en_r ? ST_ISSUE : ST_OUT;
              step_r  <= SH_H5;
            end else if (step_r == SP_NUM) begin
              state_r <= ST_DIVGO;
            end else if (step_r == SP_P8) begin
              state_r <= hum_en_r ? ST_ISSUE : ST_OUT;
              step_r  <= SH_H5;
            end else if (step_r == SH_H1) begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_DIVGO: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            step_r  <= SP_P9;
            state_r <= ST_ISSUE;
          end
        end
        ST_OUT: state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      tcent_r  <= head.tcent;
      tfine_r  <= head.tfine;
      tv_r     <= head.tv;
      rh_r     <= head.rh;
      hum_en_r <= hum_en;
      pv_r     <= 1'b0;
      hv_r     <= 1'b0;
      press_r  <= 32'd0;
      hum_r    <= 17'd0;
      a_r      <= {{32{head.tfine[31]}}, head.tfine} - 64'd128000;
      hx_r     <= head.tfine - 32'd76800;
      p_r      <= 64'd1048576 - {44'd0, head.rp[23:4]};
    end
    if (state_r == ST_DIV && div_done) begin
      p_r <= quo;
      s_r <= sra64(quo, 13);
    end
    if (state_r == ST_WAIT && mul_done) begin
      case (step_r)
        SP_AA:   aa_r <= mprod;
        SP_B6:   b_r  <= mprod;
        SP_B5:   b_r  <= b_r + (mprod << 17) + (p4 << 35);
        SP_A3:   a2_r <= sra64(mprod, 8);
        SP_A2:   a2_r <= a2_r + (mprod << 12);
        SP_A1:   aq_r <= sra64(mprod, 33);
        SP_NUM:  num_r <= mprod;
        SP_P9:   t_r  <= mprod;
        SP_P9S:  a3_r <= sra64(mprod, 25);
        SP_P8: begin
          pv_r <= 1'b1;
          if ($signed(rr) > 64'sd2147483647) begin
            press_r <= 32'h7FFF_FFFF;
          end else if ($signed(rr) < -64'sd2147483648) begin
            press_r <= 32'h8000_0000;
          end else begin
            press_r <= rr[31:0];
          end
        end
        SH_H5:   ta_r <= sra32(({2'b00, rh_r, 14'd0}) - {h4[11:0], 20'd0} - m32 + 32'd16384, 15);
        SH_H6:   b1_r <= sra32(m32, 10);
        SH_H3:   b2_r <= sra32(m32, 11) + 32'd32768;
        SH_B12:  c_r  <= sra32(m32, 10) + 32'd2097152;
        SH_H2:   tb_r <= sra32(m32 + 32'd8192, 14);
        SH_TATB: v_r  <= m32;
        SH_VV:   u_r  <= sra32(m32, 7);
        SH_H1: begin
          hv_r <= 1'b1;
          if ($signed(vv32) < 32'sd0) begin
            hum_r <= 17'd0;
          end else if ($signed(vv32) > 32'sd419430400) begin
            hum_r <= 17'd102400;
          end else begin
            hum_r <= vv32[28:12];
          end
        end
        default: t_r <= t_r;
      endcase
    end
  end

  // result ports
  assign out_valid             = (state_r == ST_OUT);
  assign out_temperature_centi = tcent_r;
  assign out_fine_temperature  = tfine_r;
  assign out_pressure_pa       = press_r;
  assign out_humidity_q10      = hum_r;
  assign out_temp_valid        = tv_r;
  assign out_press_valid       = pv_r;
  assign out_hum_valid         = hv_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_flags_follow_temp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_temp_valid |-> !out_press_valid && !out_hum_valid)
    else $error("pressure or humidity valid without temperature");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r != ST_IDLE)
    else $error("item popped but sequencer stayed idle");

endmodule
`default_nettype wire

// ===== design/env_sensor_compensation_core.sv =====
// top level: calibration registers, temperature front end, item queue, compensation back end
// Flow: the temperature pipeline, then a back-end pass of up to 18 multiplies on the shared
//   multiplier and, with pressure on, the 64-bit pressure division, plus idle and output states;
//   the pass is shorter with pressure off and shortest with temperature off.
// Throughput: start may be taken every cycle until QUEUE_DEPTH items are queued or in flight;
//   sustained rate is one item per back-end pass, set by the shared multiplier and divider.
// Reset: synchronous active-low rst_n clears control and the calibration registers to zero.
// Results appear with out_valid for one cycle; the receiver cannot stall.
`default_nettype none
module env_sensor_compensation_core
  import esc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_raw_temperature,
  input  wire logic [23:0] in_raw_pressure,
  input  wire logic [15:0] in_raw_humidity,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata,
  output logic             out_valid,
  output logic [31:0]      out_temperature_centi,
  output logic [31:0]      out_fine_temperature,
  output logic [31:0]      out_pressure_pa,
  output logic [16:0]      out_humidity_q10,
  output logic             out_temp_valid,
  output logic             out_press_valid,
  output logic             out_hum_valid
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  esc_cfg_t  cfg_r;
  esc_item_t push_item, head;
  logic      push, pop, q_empty;
  logic [CW-1:0] q_count;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TEMP:    cfg_r.temp    <= cfg_wdata[47:0];
        CFG_PRESS_A: cfg_r.press_a <= cfg_wdata;
        CFG_PRESS_B: cfg_r.press_b <= cfg_wdata;
        CFG_MIXED:   cfg_r.mixed   <= cfg_wdata[47:0];
        CFG_HUM:     cfg_r.hum     <= cfg_wdata[31:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  esc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .raw_temperature (in_raw_temperature),
    .raw_pressure    (in_raw_pressure),
    .raw_humidity    (in_raw_humidity),
    .temp_coeffs     (cfg_r.temp),
    .q_count         (q_count),
    .push            (push),
    .push_item       (push_item)
  );

  esc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .count     (q_count)
  );

  esc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .head                  (head),
    .pop                   (pop),
    .cfg                   (cfg_r),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_fine_temperature  (out_fine_temperature),
    .out_pressure_pa       (out_pressure_pa),
    .out_humidity_q10      (out_humidity_q10),
    .out_temp_valid        (out_temp_valid),
    .out_press_valid       (out_press_valid),
    .out_hum_valid         (out_hum_valid)
  );

endmodule
`default_nettype wire

// ===== test/env_sensor_compensation_core_test.sv =====
// testbench for the sensor compensation core: directed table, random items, predictor check
module env_sensor_compensation_core_test
  import esc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT = 1300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int NUM_DIRECTED = 14;

  typedef struct packed {
    logic [31:0] tcent;
    logic [31:0] tfine;
    logic [31:0] press;
    logic [16:0] hum;
    logic        tv;
    logic        pv;
    logic        hv;
  } reading_t;

  typedef struct packed {
    logic [23:0] rt;
    logic [23:0] rp;
    logic [15:0] rh;
    logic        has_known;
    reading_t    known;
  } sample_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] in_raw_temperature = '0;
  logic [23:0] in_raw_pressure = '0;
  logic [15:0] in_raw_humidity = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;
  logic        out_valid;
  logic [31:0] out_temperature_centi;
  logic [31:0] out_fine_temperature;
  logic [31:0] out_pressure_pa;
  logic [16:0] out_humidity_q10;
  logic        out_temp_valid;
  logic        out_press_valid;
  logic        out_hum_valid;

  // model copy of the calibration registers
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_press_a = '0;
  logic [63:0] cal_press_b = '0;
  logic [47:0] cal_mixed = '0;
  logic [31:0] cal_hum = '0;

  reading_t    pending_readings[$];
  int          mismatch_count = 0;
  int          reading_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          sent_count = 0;

  env_sensor_compensation_core i_dut (.*);

  always #5 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // compensation predictor for one sample
  function automatic reading_t compensate(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh);
    reading_t r;
    logic signed [31:0] adc_t, t1, t2, t3, dd, v1, v2, tf;
    logic signed [63:0] a, b, p, num, den, q, sat;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, x, ta, b1, b2, tb, v;
    r = '0;
    r.tv = (rt != TEMP_OFF_CODE);
    if (!r.tv) return r;
    adc_t = 32'(rt >> 4);
    t1 = 32'(cal_temp[15:0]);
    t2 = 32'(signed'(cal_temp[31:16]));
    t3 = 32'(signed'(cal_temp[47:32]));
    dd = (adc_t >>> 4) - t1;
    v1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    v2 = (((dd * dd) >>> 12) * t3) >>> 14;
    tf = v1 + v2;
    r.tfine = tf;
    r.tcent = (tf * 5 + 128) >>> 8;
    if (rp != PRESS_OFF_CODE) begin
      p1 = 64'(cal_press_a[15:0]);
      p2 = 64'(signed'(cal_press_a[31:16]));
      p3 = 64'(signed'(cal_press_a[47:32]));
      p4 = 64'(signed'(cal_press_a[63:48]));
      p5 = 64'(signed'(cal_press_b[15:0]));
      p6 = 64'(signed'(cal_press_b[31:16]));
      p7 = 64'(signed'(cal_press_b[47:32]));
      p8 = 64'(signed'(cal_press_b[63:48]));
      p9 = 64'(signed'(cal_mixed[15:0]));
      a = 64'(tf) - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = ((64'sd1 <<< 47) + a) * p1;
      a = a >>> 33;
      if (a != 0) begin
        p = 64'sd1048576 - 64'(rp >> 4);
        num = ((p <<< 31) - b) * 3125;
        den = a;
        if (den == -1) p = -num;
        else begin
          q = num / den;
          p = q;
        end
        a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        b = (p8 * p) >>> 19;
        p = ((p + a + b) >>> 8) + (p7 <<< 4);
        sat = p >>> 8;
        if (sat > 64'sd2147483647) sat = 64'sd2147483647;
        if (sat < -64'sd2147483648) sat = -64'sd2147483648;
        r.press = sat[31:0];
        r.pv = 1'b1;
      end
    end
    if (rh != HUM_OFF_CODE) begin
      h1 = 32'(cal_mixed[23:16]);
      h2 = 32'(signed'(cal_mixed[39:24]));
      h3 = 32'(cal_mixed[47:40]);
      h4 = 32'(signed'(cal_hum[11:0]));
      h5 = 32'(signed'(cal_hum[23:12]));
      h6 = 32'(signed'(cal_hum[31:24]));
      x = tf - 76800;
      ta = (($signed(32'(rh)) <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
      b1 = (x * h6) >>> 10;
      b2 = ((x * h3) >>> 11) + 32768;
      tb = (((((b1 * b2) >>> 10) + 2097152) * h2) + 8192) >>> 14;
      v = ta * tb;
      v = v - (((((v >>> 15) * (v >>> 15)) >>> 7) * h1) >>> 4);
      if (v < 0) v = 0;
      if (v > 419430400) v = 419430400;
      r.hum = 17'(v >>> 12);
      r.hv = 1'b1;
    end
    return r;
  endfunction

  // result check against the oldest expectation
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_temperature_centi, out_fine_temperature, out_pressure_pa, out_humidity_q10,
              out_temp_valid, out_press_valid, out_hum_valid};
      reading_count <= reading_count + 1;
      if (pending_readings.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected result %h", got);
      end else begin
        want = pending_readings.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("mismatch: expected tc=%h tf=%h p=%h h=%h v=%b%b%b, got tc=%h tf=%h p=%h h=%h v=%b%b%b",
                     want.tcent, want.tfine, want.press, want.hum, want.tv, want.pv, want.hv,
                     got.tcent, got.tfine, got.press, got.hum, got.tv, got.pv, got.hv);
        end
      end
    end
  end

  // register write while the block is idle; the caller drops the write enable
  task automatic write_cal(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_TEMP:    cal_temp = data[47:0];
      CFG_PRESS_A: cal_press_a = data;
      CFG_PRESS_B: cal_press_b = data;
      CFG_MIXED:   cal_mixed = data[47:0];
      CFG_HUM:     cal_hum = data[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] t, logic [63:0] pa, logic [63:0] pb, logic [47:0] m,
                          logic [31:0] h);
    write_cal(CFG_TEMP, {16'h0, t});
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_MIXED, {16'h0, m});
    write_cal(CFG_HUM, {32'h0, h});
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one item through the start/busy handshake, with optional sender gap
  task automatic send_sample(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh,
                             bit has_known, reading_t known);
    reading_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    r = compensate(rt, rp, rh);
    if (has_known && known !== r) begin
      mismatch_count++;
      $display("predictor disagrees with table row %h: %h", known, r);
    end
    start <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    in_raw_humidity <= rh;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_readings.push_back(r);
    sent_count++;
  endtask

  // typical factory calibration
  task automatic load_typical();
    load_cal({16'hFC18, 16'h6A4E, 16'h6E1E},
             {16'h1C0A, 16'h0BD0, 16'hD5B5, 16'h8E4C},
             {16'h2710, 16'hC1CA, 16'hFFF9, 16'h002D},
             {8'h00, 16'h0160, 8'h4B, 16'h1770},
             {8'h1E, 12'h032, 12'h141});
  endtask

  task automatic random_cal();
    logic [63:0] w [5];
    for (int i = 0; i < 5; i++) w[i] = {$urandom, $urandom};
    load_cal(w[0][47:0], w[1], w[2], w[3][47:0], w[4][31:0]);
  endtask

  // directed rows: readable expectations only where obvious
  sample_row_t directed_rows [NUM_DIRECTED];

  initial begin
    reading_t none, off_all, zero_cal;
    int row_kind;
    logic [23:0] rt, rp;
    logic [15:0] rh;
    none = '0;
    off_all = '0;
    // with all coefficients zero, divisor is zero and humidity collapses to zero
    zero_cal = '0;
    zero_cal.tv = 1'b1;
    zero_cal.hv = 1'b1;
    directed_rows = '{
      '{TEMP_OFF_CODE, 24'h0, 16'h0, 1'b1, off_all},
      '{TEMP_OFF_CODE, 24'hFFFFFF, 16'hFFFF, 1'b1, off_all},
      '{24'h0, 24'h0, 16'h0, 1'b1, zero_cal},
      '{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, zero_cal},
      '{24'h7FFFFF, PRESS_OFF_CODE, HUM_OFF_CODE, 1'b1, '{0, 0, 0, 0, 1'b1, 1'b0, 1'b0}},
      '{24'h7EE000, 24'h5C0000, 16'h6A00, 1'b0, none},
      '{24'h000000, 24'h000000, 16'h0000, 1'b0, none},
      '{24'hFFFFF0, 24'hFFFFF0, 16'hFFFF, 1'b0, none},
      '{24'h80000F, 24'h800010, 16'h8001, 1'b0, none},
      '{24'h7FFFFF, PRESS_OFF_CODE, 16'h7FFF, 1'b0, none},
      '{24'h655550, 24'h000000, HUM_OFF_CODE, 1'b0, none},
      '{TEMP_OFF_CODE, 24'h5C0000, 16'h6A00, 1'b1, off_all},
      '{24'h123450, 24'hFEDCB0, 16'h0001, 1'b0, none},
      '{24'hAAAAAA, 24'h555555, 16'hAAAA, 1'b0, none}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero calibration, then typical, then extremes of coefficients
    for (int i = 0; i < 5; i++)
      send_sample(directed_rows[i].rt, directed_rows[i].rp, directed_rows[i].rh,
                  directed_rows[i].has_known, directed_rows[i].known);
    wait_drained();
    load_typical();
    write_cal(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_we <= 1'b0;
    for (int i = 5; i < NUM_DIRECTED; i++)
      send_sample(directed_rows[i].rt, directed_rows[i].rp, directed_rows[i].rh,
                  directed_rows[i].has_known, directed_rows[i].known);
    wait_drained();
    load_cal('1, '1, '1, '1, '1);
    send_sample(24'h7FFFFF, 24'h000000, 16'hFFFF, 1'b0, none);
    send_sample(24'h000000, 24'hFFFFFF, 16'h0000, 1'b0, none);
    wait_drained();
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, {8'hFF, 16'h7FFF, 8'hFF, 16'h8000},
             {8'h80, 12'h7FF, 12'h800});
    send_sample(24'h123456, 24'h000000, 16'hFFFF, 1'b0, none);
    send_sample(24'hFFFFFF, 24'h7FFFFF, 16'h0000, 1'b0, none);

    // random phases under different idling and calibrations
    for (int phase = 0; phase < 13; phase++) begin
      wait_drained();
      idle_pct = (phase < 4) ? 23 : (phase < 8) ? 60 : 0;
      if (phase % 3 == 0) load_typical();
      else random_cal();
      for (int n = 0; n < ITEM_COUNT / 13; n++) begin
        row_kind = $urandom_range(99);
        // mostly plausible readings near typical codes, some noise and disabled codes
        if (row_kind < 60) begin
          rt = 24'h600000 + 24'($urandom_range(24'h3FFFFF));
          rp = 24'h400000 + 24'($urandom_range(24'h3FFFFF));
          rh = 16'h5000 + 16'($urandom_range(16'h3FFF));
        end else begin
          rt = 24'($urandom);
          rp = 24'($urandom);
          rh = 16'($urandom);
        end
        if (row_kind % 17 == 0) rt = TEMP_OFF_CODE;
        if (row_kind % 11 == 0) rp = PRESS_OFF_CODE;
        if (row_kind % 13 == 0) rh = HUM_OFF_CODE;
        send_sample(rt, rp, rh, 1'b0, none);
        // hold off until all results are back
        if (n == 40) begin
          start <= 1'b0;
          while (pending_readings.size() != 0) @(posedge clk);
        end
      end
    end

    wait_drained();
    $display("covered %0d items over zero, typical, extreme and random calibrations", sent_count);
    $display("checked %0d results, %0d mismatches", reading_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
